// ----- rtl/core/cbd_pkg.sv -----
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types and constants of the chunked body decoder: decoder phases,
// the per-item decode state, the result layout and the character codes.
// ----------------------------------------------------------------------------
package cbd_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_DATA    = 3'd2,
    PH_END_CR  = 3'd3,
    PH_END_LF  = 3'd4,
    PH_TRAILER = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_e;

  // State carried from one item to the next
  typedef struct packed {
    phase_e      phase;
    logic [31:0] remaining;
    logic [3:0]  digit_count;
    logic        line_has_content;
  } dec_state_t;

  // One result item
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       consumed;
    logic       done_res;
    logic       error;
  } dec_result_t;

  localparam dec_state_t StateClear = '{
    phase:            PH_SIZE,
    remaining:        32'd0,
    digit_count:      4'd0,
    line_has_content: 1'b0
  };

  localparam logic [31:0] MaxChunkReset = 32'h0FFF_FFFF;
  localparam logic [3:0]  MaxDigits     = 4'd8;

  // Character codes
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSemi  = 8'h3B;

endpackage

// ----- rtl/core/cbd_step.sv -----
// ----------------------------------------------------------------------------
// cbd_step
// Combinational decode of one body byte: takes the current decoder state
// and the registered input item, returns the next state and the result.
// ----------------------------------------------------------------------------
module cbd_step import cbd_pkg::*; (
  input  dec_state_t  state_i,
  input  logic        begin_body_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] max_chunk_size_i,
  output dec_state_t  state_o,
  output dec_result_t result_o
);

  dec_state_t  cur;
  dec_state_t  nxt;
  logic        ok;
  logic        valid;
  logic        active;
  logic        is_lf;
  logic        is_skip;
  logic        is_hex;
  logic [3:0]  hex_val;
  logic [31:0] max_div;
  logic [31:0] rem_dec;

  assign max_div = max_chunk_size_i >> 4;
  assign is_lf   = (data_byte_i == ChLf);
  assign is_skip = (data_byte_i == ChCr) || (data_byte_i == ChSpace) ||
                   (data_byte_i == ChTab);

  // Classify a hex digit and take its value
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (data_byte_i inside {[8'h30:8'h39]}) begin
      hex_val = data_byte_i[3:0];
    end else if (data_byte_i inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_val = 4'd9 + data_byte_i[3:0];
    end else begin
      is_hex = 1'b0;
    end
  end

  // Start over on begin_body
  assign cur     = begin_body_i ? StateClear : state_i;
  assign rem_dec = (cur.remaining != 32'd0) ? cur.remaining - 32'd1 : 32'd0;
  assign active  = (cur.phase != PH_DONE) && (cur.phase != PH_ERROR);

  // Advance the phase for one byte
  always_comb begin
    nxt   = cur;
    ok    = 1'b1;
    valid = 1'b0;
    case (cur.phase)
      PH_SIZE, PH_EXT: begin
        if (is_lf) begin
          if (cur.digit_count == 4'd0) begin
            ok = 1'b0;
          end else begin
            nxt.digit_count = 4'd0;
            if (cur.remaining == 32'd0) begin
              nxt.phase            = PH_TRAILER;
              nxt.line_has_content = 1'b0;
            end else begin
              nxt.phase = PH_DATA;
            end
          end
        end else if (cur.phase == PH_EXT || is_skip) begin
          // skip extension text and whitespace
        end else if (data_byte_i == ChSemi) begin
          nxt.phase = PH_EXT;
        end else if (!is_hex || cur.remaining > max_div) begin
          ok = 1'b0;
        end else begin
          nxt.remaining   = {cur.remaining[27:0], hex_val};
          nxt.digit_count = cur.digit_count + 4'd1;
          if (cur.digit_count == MaxDigits) begin
            ok = 1'b0;
          end
        end
      end
      PH_DATA: begin
        valid         = 1'b1;
        nxt.remaining = rem_dec;
        if (rem_dec == 32'd0) begin
          nxt.phase = PH_END_CR;
        end
      end
      PH_END_CR: begin
        if (data_byte_i == ChCr) begin
          nxt.phase = PH_END_LF;
        end else if (is_lf) begin
          nxt.phase = PH_SIZE;
        end else begin
          ok = 1'b0;
        end
      end
      PH_END_LF: begin
        if (is_lf) begin
          nxt.phase = PH_SIZE;
        end else begin
          ok = 1'b0;
        end
      end
      PH_TRAILER: begin
        if (is_lf) begin
          if (!cur.line_has_content) begin
            nxt.phase = PH_DONE;
          end
          nxt.line_has_content = 1'b0;
        end else if (data_byte_i != ChCr) begin
          nxt.line_has_content = 1'b1;
        end
      end
      default: begin
        // done or error: hold
      end
    endcase
    if (active && !ok) begin
      nxt.phase = PH_ERROR;
      valid     = 1'b0;
    end
  end

  // Build the result item
  always_comb begin
    state_o                = nxt;
    result_o.payload_valid = valid;
    result_o.payload_byte  = valid ? data_byte_i : 8'd0;
    result_o.consumed      = active && ok;
    result_o.done_res      = (nxt.phase == PH_DONE);
    result_o.error         = (nxt.phase == PH_ERROR);
  end

endmodule

// ----- rtl/core/chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// chunked_body_decoder
// HTTP/1.1 chunked body decoder, one raw byte per item, one result per item.
// The input register loads at acceptance, then the result register loads with
// the decode of the registered item. Throughput: 1 item per cycle while the
// result stream does not stall (a pending result with m_axis_tready low holds
// the input); the decode state is updated in the same cycle the result
// register loads. Reset clears the pipeline and decoder state and sets
// max_chunk_size to 0x0FFFFFFF; no clearing pass is needed.
// ----------------------------------------------------------------------------
module chunked_body_decoder import cbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: max_chunk_size
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] begin_body
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [8] consumed,
                                      // [9] done_res, [10] error, rest zero
  output logic        m_axis_tuser    // [0] payload_valid
);

  logic [31:0] max_chunk_size_q;
  logic        in_vld_q;
  logic        in_begin_q;
  logic [7:0]  in_byte_q;
  dec_state_t  state_q;
  dec_state_t  state_d;
  dec_result_t res_d;
  dec_result_t res_q;
  logic        out_vld_q;
  logic        advance;
  logic        in_take;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_size_q <= MaxChunkReset;
    end else if (cfg_we_i) begin
      max_chunk_size_q <= cfg_wdata_i;
    end
  end

  // Flow control: decode when the result register is free or being drained
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_begin_q <= s_axis_tuser;
      in_byte_q  <= s_axis_tdata;
    end
  end

  // Decode step
  cbd_step u_step (
    .state_i          (state_q),
    .begin_body_i     (in_begin_q),
    .data_byte_i      (in_byte_q),
    .max_chunk_size_i (max_chunk_size_q),
    .state_o          (state_d),
    .result_o         (res_d)
  );

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateClear;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Drive the result stream
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.payload_valid;
  assign m_axis_tdata  = {5'd0, res_q.error, res_q.done_res, res_q.consumed,
                          res_q.payload_byte};

endmodule
